/* rtl/core/hds_pkg.sv */
// ----------------------------------------------------------------------------
// hds_pkg
// shared types, constants and helpers of the heat diffusion stencil
// ----------------------------------------------------------------------------
package hds_pkg;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;

	localparam int TEMP_W  = 16;
	localparam int ENTRY_W = 18;
	localparam int GEOM_W  = 10;
	localparam int CFG_W   = 16;

	localparam logic [15:0] LIQ_SCALE = 16'd13107;

	localparam logic [GEOM_W-1:0] RST_GRID_WIDTH  = 10'd400;
	localparam logic [GEOM_W-1:0] RST_GRID_HEIGHT = 10'd300;
	localparam logic [CFG_W-1:0]  RST_AMBIENT     = 16'd800;
	localparam logic [CFG_W-1:0]  RST_FACTOR_MAT  = 16'd3146;
	localparam logic [CFG_W-1:0]  RST_FACTOR_AIR  = 16'd524;
	localparam logic [CFG_W-1:0]  RST_COOL_MAT    = 16'd2147;
	localparam logic [CFG_W-1:0]  RST_COOL_AIR    = 16'd268;

	typedef enum logic [2:0] {
		REG_GRID_WIDTH  = 3'd0,
		REG_GRID_HEIGHT = 3'd1,
		REG_AMBIENT     = 3'd2,
		REG_FACTOR_MAT  = 3'd3,
		REG_FACTOR_AIR  = 3'd4,
		REG_COOL_MAT    = 3'd5,
		REG_COOL_AIR    = 3'd6
	} reg_idx_t;

	// how the result of one cell is formed
	typedef enum logic [1:0] {
		MODE_AMBIENT  = 2'd0,
		MODE_KEEP     = 2'd1,
		MODE_INTERIOR = 2'd2
	} mode_t;

	typedef struct packed {
		logic  valid;
		mode_t mode;
		logic  last;
	} emit_t;

	// factor times 0.2, rounded half up
	function automatic logic [CFG_W-1:0] liquid_scale(input logic [CFG_W-1:0] f);
		logic [29:0] p;
		p = 30'(f) * 30'(LIQ_SCALE) + 30'd32768;
		return 16'(p[29:16]);
	endfunction

endpackage

/* rtl/core/hds_ram.sv */
// ----------------------------------------------------------------------------
// hds_ram
// row store copy, one write port and two registered read ports
// ----------------------------------------------------------------------------
module hds_ram #(
	parameter int DEPTH = 1026,
	parameter int DW    = 18
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [DW-1:0]            rdata_a_q,
	output logic [DW-1:0]            rdata_b_q
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a_q <= mem[raddr_a];
			rdata_b_q <= mem[raddr_b];
		end
	end

endmodule

/* rtl/core/hds_seq.sv */
// ----------------------------------------------------------------------------
// hds_seq
// input side: write pointer, pending count, result position and addresses
// ----------------------------------------------------------------------------
module hds_seq #(
	parameter int MAX_WIDTH  = hds_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hds_pkg::DEF_MAX_HEIGHT,
	parameter int DEPTH      = 2 * MAX_WIDTH + 2,
	parameter int AW         = $clog2(DEPTH),
	parameter int WB         = $clog2(MAX_WIDTH + 1),
	parameter int HB         = $clog2(MAX_HEIGHT + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           req_type,
	input  logic           adv,
	input  logic [WB-1:0]  width_eff,
	input  logic [HB-1:0]  height_eff,
	output logic           we,
	output logic [AW-1:0]  wr_addr,
	output logic [AW-1:0]  addr_c,
	output logic [AW-1:0]  addr_r,
	output logic [AW-1:0]  addr_u,
	output logic [AW-1:0]  addr_d,
	output hds_pkg::emit_t emit
);

	localparam int PB = $clog2(DEPTH + 1);
	localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);

	logic [AW-1:0] wr_q, rp_q;
	logic [PB-1:0] pending_q;
	logic [WB-1:0] col_q;
	logic [HB-1:0] row_q;

	logic          accept, is_cell, emit_now;
	logic [WB-1:0] col_inc;
	logic [HB-1:0] row_inc;
	logic [AW:0]   sum_d, sum_u;
	logic          col_end, row_end;

	assign accept  = in_valid & adv;
	assign is_cell = ~req_type;
	assign col_inc = WB'(col_q) + WB'(1);
	assign row_inc = HB'(row_q) + HB'(1);
	assign col_end = col_inc >= width_eff;
	assign row_end = row_inc >= height_eff;

	always_comb begin
		if (is_cell) begin
			emit_now = accept && (pending_q > PB'(width_eff));
		end else begin
			emit_now = accept && (pending_q != '0);
		end
	end

	// neighbor addresses around the result position, modulo the ring depth
	assign sum_d  = (AW + 1)'(rp_q) + (AW + 1)'(width_eff);
	assign sum_u  = (AW + 1)'(rp_q) + DEPTH_X - (AW + 1)'(width_eff);
	assign addr_c = rp_q;
	assign addr_r = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
	assign addr_d = (sum_d >= DEPTH_X) ? AW'(sum_d - DEPTH_X) : AW'(sum_d);
	assign addr_u = (sum_u >= DEPTH_X) ? AW'(sum_u - DEPTH_X) : AW'(sum_u);

	assign we      = accept & is_cell;
	assign wr_addr = wr_q;

	always_comb begin
		emit.valid = emit_now;
		emit.last  = row_end & col_end;
		if (row_q == '0 || col_q == '0 || col_end) begin
			emit.mode = hds_pkg::MODE_AMBIENT;
		end else if (row_end) begin
			emit.mode = hds_pkg::MODE_KEEP;
		end else begin
			emit.mode = hds_pkg::MODE_INTERIOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			rp_q      <= '0;
			pending_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else begin
			if (we) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (emit_now) begin
				rp_q <= addr_r;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_inc;
				end else begin
					col_q <= col_inc;
				end
			end
			if (we && pending_q != PB'(DEPTH)) begin
				if (!emit_now) begin
					pending_q <= pending_q + PB'(1);
				end
			end else if (emit_now) begin
				pending_q <= pending_q - PB'(1);
			end
		end
	end

endmodule

/* rtl/core/hds_calc.sv */
// ----------------------------------------------------------------------------
// hds_calc
// stencil arithmetic pipeline and output register
// ----------------------------------------------------------------------------
module hds_calc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hds_pkg::emit_t              emit,
	input  logic [hds_pkg::ENTRY_W-1:0] ent_c,
	input  logic [hds_pkg::ENTRY_W-1:0] ent_r,
	input  logic [hds_pkg::ENTRY_W-1:0] ent_u,
	input  logic [hds_pkg::ENTRY_W-1:0] ent_d,
	input  logic [15:0]                 ambient,
	input  logic [15:0]                 factor_mat,
	input  logic [15:0]                 factor_air,
	input  logic [15:0]                 cool_mat,
	input  logic [15:0]                 cool_air,
	input  logic [15:0]                 factor_liq,
	input  logic [15:0]                 cool_liq,
	output logic                        adv,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [15:0]                 out_temp,
	output logic                        out_last
);

	// stage 1
	logic                  v_s1, last_s1;
	hds_pkg::mode_t        mode_s1;
	logic [15:0]           left_q;
	// stage 2
	logic                  v_s2, last_s2, mat_s2;
	hds_pkg::mode_t        mode_s2;
	logic [15:0]           c_s2, k_s2;
	logic signed [35:0]    prod_s2;
	// stage 3
	logic                  v_s3, last_s3, mat_s3;
	hds_pkg::mode_t        mode_s3;
	logic [15:0]           c_s3;
	logic signed [20:0]    t1_s3;
	logic signed [38:0]    prod_s3;

	logic en_o, en_s3, en_s2;

	assign en_o  = ~out_valid | out_ready;
	assign en_s3 = en_o | ~v_s3;
	assign en_s2 = en_s3 | ~v_s2;
	assign adv   = en_s2 | ~v_s1;

	// stage 1: laplacian, factor select, first product
	logic               mat1, liq1;
	logic signed [18:0] lap;
	logic [15:0]        f_sel, k_sel;
	logic signed [35:0] prod1;

	assign mat1 = ent_c[16];
	assign liq1 = ent_c[16] & ent_c[17];
	assign lap  = 19'(signed'(left_q)) + 19'(signed'(ent_r[15:0]))
		+ 19'(signed'(ent_u[15:0])) + 19'(signed'(ent_d[15:0]))
		- (19'(signed'(ent_c[15:0])) <<< 2);

	always_comb begin
		if (!mat1) begin
			f_sel = factor_air;
			k_sel = cool_air;
		end else if (liq1) begin
			f_sel = factor_liq;
			k_sel = cool_liq;
		end else begin
			f_sel = factor_mat;
			k_sel = cool_mat;
		end
	end

	assign prod1 = 36'($signed({1'b0, f_sel})) * 36'(lap);

	// stage 2: t1 and cooling product
	logic signed [35:0] pr1;
	logic signed [20:0] t1;
	logic signed [21:0] diff;
	logic signed [38:0] prod2;

	assign pr1   = prod_s2 + 36'sh8000;
	assign t1    = 21'(signed'(c_s2)) + {pr1[35], pr1[35:16]};
	assign diff  = 22'(signed'(ambient)) - 22'(t1);
	assign prod2 = 39'($signed({1'b0, k_s2})) * 39'(diff);

	// stage 3: final sum, saturation, boundary select
	logic signed [38:0] pr2;
	logic signed [21:0] res;
	logic [15:0]        sat, fin;

	assign pr2 = prod_s3 + 39'sh800000;
	assign res = 22'(t1_s3) + 22'(signed'(pr2[38:24]));

	always_comb begin
		if (res > 22'sd32767) begin
			sat = 16'h7fff;
		end else if (res < -22'sd32768) begin
			sat = 16'h8000;
		end else begin
			sat = res[15:0];
		end
		unique case (mode_s3)
			hds_pkg::MODE_AMBIENT:  fin = ambient;
			hds_pkg::MODE_KEEP:     fin = mat_s3 ? c_s3 : ambient;
			hds_pkg::MODE_INTERIOR: fin = sat;
			default:                fin = ambient;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= emit.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_o) begin
				out_valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= emit.mode;
			last_s1 <= emit.last;
		end
		if (en_s2) begin
			mode_s2 <= mode_s1;
			last_s2 <= last_s1;
			mat_s2  <= mat1;
			c_s2    <= ent_c[15:0];
			k_s2    <= k_sel;
			prod_s2 <= prod1;
		end
		// left neighbor is the center of the previous result
		if (en_s2 && v_s1) begin
			left_q <= ent_c[15:0];
		end
		if (en_s3) begin
			mode_s3 <= mode_s2;
			last_s3 <= last_s2;
			mat_s3  <= mat_s2;
			c_s3    <= c_s2;
			t1_s3   <= t1;
			prod_s3 <= prod2;
		end
		if (en_o) begin
			out_temp <= fin;
			out_last <= last_s3;
		end
	end

endmodule

/* rtl/core/heat_diffusion_stencil.sv */
// ----------------------------------------------------------------------------
// heat_diffusion_stencil
// one explicit heat equation step over a raster stream of grid cells
// ----------------------------------------------------------------------------
// usage
//  - s_* channel takes items in raster order; s_tuser low carries a cell,
//    s_tuser high is a flush that drains one pending result
//  - m_* channel gives one new temperature per result, m_tlast on the last
//    cell of the frame
//  - apb port holds geometry, ambient, diffusion and cooling registers;
//    write them only while no result is outstanding
//  - a cell's result is released by the item that arrives one row plus one
//    cell later, then moves through stages 1 to 3 and the output register
//  - one item per cycle sustained while the receiver keeps up; the row store
//    copies each offer one write and two reads per cycle, the laplacian and
//    the cooling products each take a stage of their own
//  - a stalled receiver holds the output register; the three stages drain
//    into free slots, so items keep being accepted until all are full
//  - reset clears pointers, counters and valids and loads register defaults;
//    the row store itself needs no clearing
// ----------------------------------------------------------------------------
module heat_diffusion_stencil #(
	parameter int MAX_WIDTH  = hds_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hds_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // cell_temp[15:0], cell_is_material[16], cell_is_liquid[17]
	input  logic        s_tuser,   // req_type
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // new_temp[15:0]
	output logic        m_tlast,   // frame_last
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH = 2 * MAX_WIDTH + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int WB    = $clog2(MAX_WIDTH + 1);
	localparam int HB    = $clog2(MAX_HEIGHT + 1);

	// configuration registers
	logic [9:0]  grid_width_q, grid_height_q;
	logic [15:0] ambient_q, factor_mat_q, factor_air_q, cool_mat_q, cool_air_q;
	logic [15:0] factor_liq_q, cool_liq_q;
	logic        cfg_wr;
	hds_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = hds_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hds_pkg::RST_GRID_WIDTH;
			grid_height_q <= hds_pkg::RST_GRID_HEIGHT;
			ambient_q     <= hds_pkg::RST_AMBIENT;
			factor_mat_q  <= hds_pkg::RST_FACTOR_MAT;
			factor_air_q  <= hds_pkg::RST_FACTOR_AIR;
			cool_mat_q    <= hds_pkg::RST_COOL_MAT;
			cool_air_q    <= hds_pkg::RST_COOL_AIR;
		end else if (cfg_wr) begin
			case (cfg_idx)
				hds_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[9:0];
				hds_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[9:0];
				hds_pkg::REG_AMBIENT:     ambient_q     <= pwdata[15:0];
				hds_pkg::REG_FACTOR_MAT:  factor_mat_q  <= pwdata[15:0];
				hds_pkg::REG_FACTOR_AIR:  factor_air_q  <= pwdata[15:0];
				hds_pkg::REG_COOL_MAT:    cool_mat_q    <= pwdata[15:0];
				hds_pkg::REG_COOL_AIR:    cool_air_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			hds_pkg::REG_GRID_WIDTH:  prdata = {22'd0, grid_width_q};
			hds_pkg::REG_GRID_HEIGHT: prdata = {22'd0, grid_height_q};
			hds_pkg::REG_AMBIENT:     prdata = {16'd0, ambient_q};
			hds_pkg::REG_FACTOR_MAT:  prdata = {16'd0, factor_mat_q};
			hds_pkg::REG_FACTOR_AIR:  prdata = {16'd0, factor_air_q};
			hds_pkg::REG_COOL_MAT:    prdata = {16'd0, cool_mat_q};
			hds_pkg::REG_COOL_AIR:    prdata = {16'd0, cool_air_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// liquid variants at 0.2 of the material factor and cooling rate
	always_ff @(posedge clk) begin
		factor_liq_q <= hds_pkg::liquid_scale(factor_mat_q);
		cool_liq_q   <= hds_pkg::liquid_scale(cool_mat_q);
	end

	// geometry clamped into the supported range
	logic [WB-1:0] width_eff;
	logic [HB-1:0] height_eff;

	always_comb begin
		if (grid_width_q < 10'd3) begin
			width_eff = WB'(3);
		end else if (int'(grid_width_q) > MAX_WIDTH) begin
			width_eff = WB'(MAX_WIDTH);
		end else begin
			width_eff = WB'(grid_width_q);
		end
		if (grid_height_q < 10'd3) begin
			height_eff = HB'(3);
		end else if (int'(grid_height_q) > MAX_HEIGHT) begin
			height_eff = HB'(MAX_HEIGHT);
		end else begin
			height_eff = HB'(grid_height_q);
		end
	end

	// sequencing and row store addressing
	logic           adv, we;
	logic [AW-1:0]  wr_addr, addr_c, addr_r, addr_u, addr_d;
	hds_pkg::emit_t emit;

	hds_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.req_type   (s_tuser),
		.adv        (adv),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.we         (we),
		.wr_addr    (wr_addr),
		.addr_c     (addr_c),
		.addr_r     (addr_r),
		.addr_u     (addr_u),
		.addr_d     (addr_d),
		.emit       (emit)
	);

	assign s_tready = adv;

	// two copies of the row store: center/right and up/down
	logic [hds_pkg::ENTRY_W-1:0] ent_c, ent_r, ent_u, ent_d;

	hds_ram #(
		.DEPTH (DEPTH),
		.DW    (hds_pkg::ENTRY_W)
	) u_ram_row (
		.clk       (clk),
		.we        (we),
		.waddr     (wr_addr),
		.wdata     (s_tdata[hds_pkg::ENTRY_W-1:0]),
		.re        (adv),
		.raddr_a   (addr_c),
		.raddr_b   (addr_r),
		.rdata_a_q (ent_c),
		.rdata_b_q (ent_r)
	);

	hds_ram #(
		.DEPTH (DEPTH),
		.DW    (hds_pkg::ENTRY_W)
	) u_ram_col (
		.clk       (clk),
		.we        (we),
		.waddr     (wr_addr),
		.wdata     (s_tdata[hds_pkg::ENTRY_W-1:0]),
		.re        (adv),
		.raddr_a   (addr_u),
		.raddr_b   (addr_d),
		.rdata_a_q (ent_u),
		.rdata_b_q (ent_d)
	);

	// arithmetic pipeline
	hds_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit       (emit),
		.ent_c      (ent_c),
		.ent_r      (ent_r),
		.ent_u      (ent_u),
		.ent_d      (ent_d),
		.ambient    (ambient_q),
		.factor_mat (factor_mat_q),
		.factor_air (factor_air_q),
		.cool_mat   (cool_mat_q),
		.cool_air   (cool_air_q),
		.factor_liq (factor_liq_q),
		.cool_liq   (cool_liq_q),
		.adv        (adv),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_temp   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

/* verif/heat_diffusion_stencil_tb.sv */
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_tb
// self-checking bench for the heat equation stencil
// ----------------------------------------------------------------------------
// A built-in stencil model predicts each new temperature and its frame-last
// flag from the cells taken in. A directed table covers the boundaries, the
// extremes and the liquid rules. Random frames follow under several register
// settings. Both stream sides idle at random, and the receiver holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 2 * hds_pkg::DEF_MAX_WIDTH + 2;
	localparam logic REQ_CELL  = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // cell_temp[15:0], cell_is_material[16], cell_is_liquid[17]
	logic        s_tuser;  // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // new_temp[15:0]
	logic        m_tlast;  // frame_last
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	heat_diffusion_stencil dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// one row of the directed table; known marks a result that can be typed in
	typedef struct {
		logic        flush;
		logic [15:0] temp;
		logic        mat;
		logic        liq;
		logic        known;
		logic [15:0] known_temp;
	} cell_row_t;

	typedef struct {
		logic [15:0] temp;
		logic        last;
	} new_temp_t;

	// ------------------------------------------------------------------------
	// stencil model state
	// ------------------------------------------------------------------------
	logic [17:0]  cell_store [STORE_DEPTH];
	int unsigned  store_wr;
	int unsigned  in_col, in_row, out_col, out_row, cells_pending;
	logic [9:0]   grid_w, grid_h;
	logic signed [15:0] ambient;
	logic [15:0]  f_mat, f_air, k_mat, k_air;

	new_temp_t    temp_due_q [$];
	int           mismatches;
	int           results_seen;
	int           cells_sent;
	int           flushes_sent;

	// stream pacing controls for the sender and the receiver
	bit           tx_steady;
	bit           rx_steady;
	int           rx_long_hold;

	function automatic int unsigned clamp_dim(logic [9:0] d);
		if (d < 3)
			return 3;
		if (d > hds_pkg::DEF_MAX_WIDTH)
			return hds_pkg::DEF_MAX_WIDTH;
		return d;
	endfunction

	function automatic longint cell_temp_of(logic [17:0] e);
		return longint'($signed(e[15:0]));
	endfunction

	function automatic int unsigned wrap_idx(int unsigned pos, int d);
		return (int'(pos) + STORE_DEPTH + d) % STORE_DEPTH;
	endfunction

	// floor((v + 2^(s-1)) / 2^s)
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic int unsigned fifth_of(int unsigned f);
		return (f * 13107 + 32768) >> 16;
	endfunction

	function automatic void step_pos(inout int unsigned col, inout int unsigned row,
			input int unsigned w, input int unsigned h);
		if (col + 1 >= w) begin
			col = 0;
			row = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
	endfunction

	// next temperature of the oldest pending cell
	function automatic new_temp_t release_cell();
		int unsigned w, h, pos, f, k;
		logic [17:0] e;
		logic        mat, liq;
		longint      c, lap, t1, res;
		new_temp_t   r;
		w = clamp_dim(grid_w);
		h = clamp_dim(grid_h);
		pos = (store_wr + STORE_DEPTH - cells_pending) % STORE_DEPTH;
		e = cell_store[pos];
		c = cell_temp_of(e);
		mat = e[16];
		liq = mat && e[17];
		if (out_row == 0 || out_col == 0 || out_col + 1 >= w) begin
			res = ambient;
		end else if (out_row + 1 >= h) begin
			res = mat ? c : longint'(ambient);
		end else begin
			lap = cell_temp_of(cell_store[wrap_idx(pos, -1)])
			    + cell_temp_of(cell_store[wrap_idx(pos, 1)])
			    + cell_temp_of(cell_store[wrap_idx(pos, -int'(w))])
			    + cell_temp_of(cell_store[wrap_idx(pos, int'(w))])
			    - 4 * c;
			f = mat ? f_mat : f_air;
			k = mat ? k_mat : k_air;
			if (liq) begin
				f = fifth_of(f);
				k = fifth_of(k);
			end
			t1 = c + round_shift(longint'(f) * lap, 16);
			res = t1 + round_shift(longint'(k) * (longint'(ambient) - t1), 24);
		end
		if (res > 32767)
			res = 32767;
		if (res < -32768)
			res = -32768;
		r.temp = res[15:0];
		r.last = (out_row + 1 >= h) && (out_col + 1 >= w);
		step_pos(out_col, out_row, w, h);
		cells_pending--;
		return r;
	endfunction

	// model update for one accepted item; got tells whether a result follows
	function automatic void heat_step(logic flush, logic [15:0] temp, logic mat,
			logic liq, output logic got, output new_temp_t r);
		int unsigned w;
		w = clamp_dim(grid_w);
		got = 1'b0;
		r = '{default: '0};
		if (flush) begin
			if (cells_pending != 0) begin
				r = release_cell();
				got = 1'b1;
			end
			return;
		end
		cell_store[store_wr] = {liq, mat, temp};
		store_wr = (store_wr + 1) % STORE_DEPTH;
		if (cells_pending < STORE_DEPTH)
			cells_pending++;
		step_pos(in_col, in_row, w, clamp_dim(grid_h));
		if (cells_pending > w + 1) begin
			r = release_cell();
			got = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit far above the slowest correct run
	initial begin
		#20ms;
		$display("heat_diffusion_stencil: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// result side: random stalls, one long hold-off, compare with the model
	// ------------------------------------------------------------------------
	int rx_hold;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				int rx_wait;
				rx_wait = rx_steady ? 0 : $urandom_range(0, 19);
				results_seen++;
				if (temp_due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item: temp %0d last %b",
							$signed(m_tdata), m_tlast);
				end else begin
					new_temp_t due;
					due = temp_due_q.pop_front();
					if (due.temp !== m_tdata || due.last !== m_tlast) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected temp %0d last %b, got temp %0d last %b",
								results_seen, $signed(due.temp), due.last,
								$signed(m_tdata), m_tlast);
					end
				end
				// a wait of zero keeps the receiver ready for the next item, unless a long hold-off is set
				rx_hold <= rx_wait;
				m_tready <= (rx_wait == 0) && (rx_long_hold == 0);
			end else if (rx_long_hold > 0) begin
				// long hold-off: the pipeline fills and backs up the input
				rx_long_hold <= rx_long_hold - 1;
				m_tready <= 1'b0;
			end else if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------
	// offer one item after a random gap, wait for the handshake, then predict
	task automatic send_item(logic flush, logic [15:0] temp, logic mat, logic liq,
			logic known, logic [15:0] known_temp);
		int        gap;
		logic      got;
		new_temp_t r;
		gap = tx_steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= flush;
		s_tdata  <= {6'b0, liq, mat, temp};
		do @(posedge clk); while (!s_tready);
		heat_step(flush, temp, mat, liq, got, r);
		if (got) begin
			if (known)
				r.temp = known_temp;
			temp_due_q = {temp_due_q, r};
		end
		if (flush)
			flushes_sent++;
		else
			cells_sent++;
	endtask

	task automatic send_cell(logic [15:0] temp, logic mat, logic liq);
		send_item(REQ_CELL, temp, mat, liq, 1'b0, '0);
	endtask

	// drain pending cells with flush items and let the block go quiet
	task automatic drain_all();
		while (cells_pending != 0)
			send_item(REQ_FLUSH, 16'($urandom), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'b0, '0);
		s_tvalid <= 1'b0;
		while (temp_due_q.size() != 0)
			@(posedge clk);
		// all results have left, allow margin
		repeat (12) @(posedge clk);
	endtask

	// register write: setup cycle then access cycle
	task automatic reg_write(hds_pkg::reg_idx_t idx, logic [15:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx) << 2;
		pwdata  <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			hds_pkg::REG_GRID_WIDTH:  grid_w  = value[9:0];
			hds_pkg::REG_GRID_HEIGHT: grid_h  = value[9:0];
			hds_pkg::REG_AMBIENT:     ambient = value;
			hds_pkg::REG_FACTOR_MAT:  f_mat   = value;
			hds_pkg::REG_FACTOR_AIR:  f_air   = value;
			hds_pkg::REG_COOL_MAT:    k_mat   = value;
			hds_pkg::REG_COOL_AIR:    k_air   = value;
			default: ;
		endcase
	endtask

	task automatic set_grid(logic [15:0] w, logic [15:0] h, logic [15:0] amb,
			logic [15:0] fm, logic [15:0] fa, logic [15:0] km, logic [15:0] ka);
		reg_write(hds_pkg::REG_GRID_WIDTH, w);
		reg_write(hds_pkg::REG_GRID_HEIGHT, h);
		reg_write(hds_pkg::REG_AMBIENT, amb);
		reg_write(hds_pkg::REG_FACTOR_MAT, fm);
		reg_write(hds_pkg::REG_FACTOR_AIR, fa);
		reg_write(hds_pkg::REG_COOL_MAT, km);
		reg_write(hds_pkg::REG_COOL_AIR, ka);
	endtask

	// random temperature: mostly spread over the full range, some extremes
	function automatic logic [15:0] pick_temp();
		case ($urandom_range(0, 9))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2, 3:    return 16'($urandom_range(0, 2000)) - 16'd1000;
			default: return 16'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// directed table: one empty flush, two 3x3 frames, flushes for the tail
	// ambient is -32768 throughout, so A marks a known ambient result
	// ------------------------------------------------------------------------
	localparam logic [15:0] A = 16'h8000;
	cell_row_t dir_tab [23] = '{
		'{REQ_FLUSH, 16'd0,     1'b0, 1'b0, 1'b0, 16'd0},     // nothing pending
		'{REQ_CELL,  16'h7fff,  1'b0, 1'b0, 1'b0, 16'd0},
		'{REQ_CELL,  16'h8000,  1'b1, 1'b0, 1'b0, 16'd0},
		'{REQ_CELL,  16'h7fff,  1'b1, 1'b1, 1'b0, 16'd0},
		'{REQ_CELL,  16'h8000,  1'b0, 1'b0, 1'b0, 16'd0},
		'{REQ_CELL,  16'd0,     1'b1, 1'b1, 1'b1, A},         // top-left corner
		'{REQ_CELL,  16'h7fff,  1'b1, 1'b0, 1'b1, A},         // top row
		'{REQ_CELL,  16'hfed4,  1'b1, 1'b0, 1'b1, A},         // top-right corner
		'{REQ_CELL,  16'h7fff,  1'b1, 1'b1, 1'b1, A},         // left column
		'{REQ_CELL,  16'd12345, 1'b1, 1'b0, 1'b0, 16'd0},     // liquid interior
		'{REQ_CELL,  16'd0,     1'b0, 1'b0, 1'b1, A},         // right column
		'{REQ_CELL,  16'd1,     1'b1, 1'b0, 1'b1, A},         // bottom-left corner
		'{REQ_CELL,  16'hffff,  1'b1, 1'b1, 1'b1, 16'h7fff},  // liquid bottom material keeps
		'{REQ_CELL,  16'd100,   1'b0, 1'b0, 1'b1, A},         // bottom right, material
		'{REQ_CELL,  16'hffce,  1'b0, 1'b1, 1'b1, A},
		'{REQ_CELL,  16'hff9c,  1'b0, 1'b0, 1'b1, A},
		'{REQ_CELL,  16'd5,     1'b1, 1'b1, 1'b1, A},
		'{REQ_CELL,  16'hfff9,  1'b0, 1'b1, 1'b1, A},
		'{REQ_CELL,  16'd0,     1'b1, 1'b0, 1'b0, 16'd0},     // air interior, liquid ignored
		'{REQ_FLUSH, 16'd0,     1'b0, 1'b0, 1'b1, A},
		'{REQ_FLUSH, 16'd0,     1'b0, 1'b0, 1'b1, A},         // bottom-left corner
		'{REQ_FLUSH, 16'd0,     1'b0, 1'b0, 1'b1, A},         // bottom air
		'{REQ_FLUSH, 16'd0,     1'b0, 1'b0, 1'b1, A}
	};

	// random phases: {width, height, items}; out-of-range sizes hit the clamps
	int phase_tab [6][3] = '{
		'{7,    5,    60},
		'{1023, 1,    200},  // clamps to 512 x 3
		'{0,    1023, 50},   // clamps to 3 x 512
		'{4,    9,    50},
		'{16,   4,    60},
		'{3,    3,    40}
	};

	initial begin
		// all inputs known from time zero
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		rx_long_hold = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		mismatches = 0;
		results_seen = 0;
		cells_sent = 0;
		flushes_sent = 0;

		// model reset
		foreach (cell_store[i])
			cell_store[i] = '0;
		store_wr = 0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		cells_pending = 0;
		grid_w  = hds_pkg::RST_GRID_WIDTH;
		grid_h  = hds_pkg::RST_GRID_HEIGHT;
		ambient = hds_pkg::RST_AMBIENT;
		f_mat   = hds_pkg::RST_FACTOR_MAT;
		f_air   = hds_pkg::RST_FACTOR_AIR;
		k_mat   = hds_pkg::RST_COOL_MAT;
		k_air   = hds_pkg::RST_COOL_AIR;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part: smallest grid, largest factors, lowest ambient
		set_grid(16'd3, 16'd3, A, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		foreach (dir_tab[i])
			send_item(dir_tab[i].flush, dir_tab[i].temp, dir_tab[i].mat, dir_tab[i].liq,
				dir_tab[i].known, dir_tab[i].known_temp);
		drain_all();

		// one full frame writes every slot of the row store before any flush
		// can reach back into it
		set_grid(16'd32, 16'd33, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
		for (int i = 0; i < 32 * 33; i++) begin
			if (i == 200)
				tx_steady = 1'b1;  // a back-to-back stretch
			if (i == 400)
				tx_steady = 1'b0;
			if (i == 600)
				rx_steady = 1'b1;
			if (i == 800)
				rx_steady = 1'b0;
			send_cell(pick_temp(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		drain_all();

		// random frames under varied settings, flushes mixed in mid-frame
		foreach (phase_tab[p]) begin
			case (p)
				0: set_grid(16'(phase_tab[p][0]), 16'(phase_tab[p][1]), 16'h7fff,
					16'h0, 16'h0, 16'h0, 16'h0);
				5: set_grid(16'(phase_tab[p][0]), 16'(phase_tab[p][1]), 16'h8000,
					16'hffff, 16'hffff, 16'hffff, 16'hffff);
				default: set_grid(16'(phase_tab[p][0]), 16'(phase_tab[p][1]),
					16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			endcase
			tx_steady = (p == 1);
			for (int i = 0; i < phase_tab[p][2]; i++) begin
				// long receiver hold-off once the wide grid has results flowing
				if (p == 1 && i == 150)
					rx_long_hold = 300;
				if ($urandom_range(0, 99) < 15)
					send_item(REQ_FLUSH, pick_temp(), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'b0, '0);
				else
					send_cell(pick_temp(), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end
			tx_steady = 1'b0;
			drain_all();
		end

		if (temp_due_q.size() != 0)
			mismatches++;

		$display("covered %0d cells and %0d flushes giving %0d results,", cells_sent,
			flushes_sent, results_seen);
		$display("over grids from 3x3 to clamped 512-wide, with stalls on both sides");
		if (mismatches == 0)
			$display("heat_diffusion_stencil: match");
		else
			$display("heat_diffusion_stencil: mismatch");
		$finish;
	end

endmodule
